[hw/rtl/ddt_pkg.sv]
// types and constants shared by the data directive tokenizer
package ddt_pkg;

   // result kinds
   typedef enum logic [1:0] {
      KIND_WORD  = 2'd0,
      KIND_DONE  = 2'd1,
      KIND_WRONG = 2'd2,
      KIND_OVF   = 2'd3
   } kind_type;

   // parser phase, one-hot
   typedef enum logic [4:0] {
      PH_PRE   = 5'b00001,
      PH_READ  = 5'b00010,
      PH_POST  = 5'b00100,
      PH_MINUS = 5'b01000,
      PH_BSL   = 5'b10000
   } phase_type;

   // one queued result
   typedef struct packed {
      kind_type    kind;
      logic [15:0] value;
      logic [6:0]  words;
      logic        last;
   } result_type;

   // character codes
   localparam logic [7:0] CHAR_NUL       = 8'h00;
   localparam logic [7:0] CHAR_TAB       = 8'h09;
   localparam logic [7:0] CHAR_SPACE     = 8'h20;
   localparam logic [7:0] CHAR_QUOTE     = 8'h22;
   localparam logic [7:0] CHAR_COMMA     = 8'h2C;
   localparam logic [7:0] CHAR_MINUS     = 8'h2D;
   localparam logic [7:0] CHAR_ZERO      = 8'h30;
   localparam logic [7:0] CHAR_NINE      = 8'h39;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;

   // value limits
   localparam logic [15:0] LIMIT_NEG = 16'd32767;
   localparam logic [15:0] LIMIT_POS = 16'd32766;
   localparam logic [19:0] MAG_MAX   = 20'd65535;

   // result queue
   localparam int QUEUE_DEPTH = 4;

endpackage

[hw/rtl/data_directive_tokenizer_unit.sv]
// data directive tokenizer: character parser with result queue
// results of an accepted character are registered in the result queue and offered on rsp from its head
// throughput: one character per cycle while req_stall is low; an item with two results
// takes one more queue entry, absorbed by the four-entry result queue (req_stall while fewer
// than two entries are free)
// reset: synchronous, clears the parser state and empties the result queue
module data_directive_tokenizer_unit
   import ddt_pkg::*;
#(
   parameter int LINE_CHARS = 80
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_character,
   input  logic               req_string_mode,
   input  logic               req_first_of_line,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_kind,
   output logic signed [15:0] rsp_word_value,
   output logic [6:0]         rsp_line_words,
   output logic               rsp_last
);

   localparam int WORD_CAP_INT = (LINE_CHARS < 127) ? LINE_CHARS : 127;
   localparam logic [6:0] WORD_CAP = WORD_CAP_INT[6:0];

   // parser state
   phase_type   phase_ff, phase_in;
   logic        neg_ff, neg_in;
   logic [15:0] mag_ff, mag_in;
   logic [6:0]  words_ff, words_in;
   logic        fin_ff, fin_in;

   // result queue
   result_type  queue_ff [QUEUE_DEPTH];
   logic [1:0]  wr_ptr_ff, wr_ptr_in;
   logic [1:0]  rd_ptr_ff, rd_ptr_in;
   logic [2:0]  count_ff, count_in;

   logic        req_take;
   logic        rsp_take;
   result_type  res [2];
   logic [1:0]  res_n;

   // decimal accumulate with saturation
   function automatic logic [15:0] add_digit(input logic [15:0] m, input logic [7:0] c);
      logic [19:0] sum;
      sum = ({4'b0, m} * 20'd10) + {16'b0, c[3:0]};
      return (sum > MAG_MAX) ? MAG_MAX[15:0] : sum[15:0];
   endfunction

   assign req_take = req_valid && !req_stall;
   assign rsp_take = rsp_valid && !rsp_stall;

   // parse one character
   always_comb begin
      phase_type   ph_eff;
      phase_type   ph_mode;
      logic        neg_eff;
      logic [15:0] mag_eff;
      logic [6:0]  words_w;
      logic        fin_eff;
      logic        fin_w;
      logic        is_digit;
      logic        is_blank;
      logic        num_req;
      logic [1:0]  word_cnt;
      logic [15:0] wv0;
      logic [15:0] wv1;
      logic        tail_req;
      kind_type    tail_kind;
      logic [15:0] limit;

      // a first-of-line item restarts the parser
      if (req_first_of_line) begin
         ph_eff  = PH_PRE;
         neg_eff = 1'b0;
         mag_eff = '0;
         words_w = '0;
         fin_eff = 1'b0;
      end else begin
         ph_eff  = phase_ff;
         neg_eff = neg_ff;
         mag_eff = mag_ff;
         words_w = words_ff;
         fin_eff = fin_ff;
      end

      // phases the current mode does not use fall back to before-token
      case (ph_eff)
         PH_MINUS: ph_mode = req_string_mode ? PH_PRE : PH_MINUS;
         PH_BSL:   ph_mode = req_string_mode ? PH_BSL : PH_PRE;
         PH_READ:  ph_mode = PH_READ;
         PH_POST:  ph_mode = PH_POST;
         default:  ph_mode = PH_PRE;
      endcase

      is_digit  = (req_character >= CHAR_ZERO) && (req_character <= CHAR_NINE);
      is_blank  = (req_character == CHAR_SPACE) || (req_character == CHAR_TAB);
      num_req   = 1'b0;
      word_cnt  = 2'd0;
      wv0       = '0;
      wv1       = '0;
      tail_req  = 1'b0;
      tail_kind = KIND_WRONG;
      phase_in  = ph_eff;
      neg_in    = neg_eff;
      mag_in    = mag_eff;
      fin_w     = fin_eff;
      res_n     = 2'd0;
      res[0]    = '{kind: KIND_WORD, value: '0, words: '0, last: 1'b0};
      res[1]    = '{kind: KIND_WORD, value: '0, words: '0, last: 1'b0};

      // grammar: decide the actions for this character
      if (!fin_eff) begin
         if (!req_string_mode) begin
            case (ph_mode)
               PH_PRE: begin
                  if (is_digit) begin
                     neg_in   = 1'b0;
                     mag_in   = add_digit(16'd0, req_character);
                     phase_in = PH_READ;
                  end else if (req_character == CHAR_MINUS) begin
                     neg_in   = 1'b1;
                     mag_in   = '0;
                     phase_in = PH_MINUS;
                  end else if (is_blank) begin
                     phase_in = PH_PRE;
                  end else begin
                     tail_req = 1'b1;
                  end
               end
               PH_MINUS: begin
                  if (is_digit) begin
                     mag_in   = add_digit(mag_eff, req_character);
                     phase_in = PH_READ;
                  end else begin
                     tail_req = 1'b1;
                  end
               end
               PH_READ: begin
                  if (is_digit) begin
                     mag_in = add_digit(mag_eff, req_character);
                  end else if (is_blank) begin
                     num_req  = 1'b1;
                     phase_in = PH_POST;
                  end else if (req_character == CHAR_COMMA) begin
                     num_req  = 1'b1;
                     phase_in = PH_PRE;
                  end else if (req_character == CHAR_NUL) begin
                     num_req   = 1'b1;
                     tail_req  = 1'b1;
                     tail_kind = KIND_DONE;
                  end else begin
                     tail_req = 1'b1;
                  end
               end
               default: begin
                  if (req_character == CHAR_COMMA) begin
                     phase_in = PH_PRE;
                  end else if (req_character == CHAR_NUL) begin
                     tail_req  = 1'b1;
                     tail_kind = KIND_DONE;
                  end else if (!is_blank) begin
                     tail_req = 1'b1;
                  end
               end
            endcase
         end else begin
            case (ph_mode)
               PH_PRE: begin
                  if (req_character == CHAR_QUOTE) begin
                     phase_in = PH_READ;
                  end else if (!is_blank) begin
                     tail_req = 1'b1;
                  end
               end
               PH_READ: begin
                  if (req_character == CHAR_BACKSLASH) begin
                     phase_in = PH_BSL;
                  end else if (req_character == CHAR_QUOTE) begin
                     word_cnt = 2'd1;
                     phase_in = PH_POST;
                  end else if (req_character == CHAR_NUL) begin
                     tail_req = 1'b1;
                  end else begin
                     word_cnt = 2'd1;
                     wv0      = {8'h00, req_character};
                  end
               end
               PH_BSL: begin
                  if (req_character == CHAR_NUL) begin
                     tail_req = 1'b1;
                  end else if ((req_character == CHAR_QUOTE) ||
                               (req_character == CHAR_BACKSLASH)) begin
                     word_cnt = 2'd1;
                     wv0      = {8'h00, req_character};
                  end else begin
                     word_cnt = 2'd2;
                     wv0      = {8'h00, CHAR_BACKSLASH};
                     wv1      = {8'h00, req_character};
                  end
                  phase_in = PH_READ;
               end
               default: begin
                  if (req_character == CHAR_NUL) begin
                     tail_req  = 1'b1;
                     tail_kind = KIND_DONE;
                  end else if (!is_blank) begin
                     tail_req = 1'b1;
                  end
               end
            endcase
         end
      end

      // number range check and conversion
      limit = neg_eff ? LIMIT_NEG : LIMIT_POS;
      if (num_req) begin
         if (mag_eff > limit) begin
            res[0] = '{kind: KIND_OVF, value: '0, words: words_w, last: 1'b0};
            res_n  = 2'd1;
            fin_w  = 1'b1;
         end else begin
            neg_in   = 1'b0;
            mag_in   = '0;
            word_cnt = 2'd1;
            wv0      = neg_eff ? (~mag_eff + 16'd1) : mag_eff;
         end
      end

      // first word, with the per-line word cap
      if ((word_cnt != 2'd0) && !fin_w) begin
         if (words_w >= WORD_CAP) begin
            res[res_n[0]] = '{kind: KIND_WRONG, value: '0, words: words_w, last: 1'b0};
            fin_w = 1'b1;
         end else begin
            words_w = words_w + 7'd1;
            res[res_n[0]] = '{kind: KIND_WORD, value: wv0, words: words_w, last: 1'b0};
         end
         res_n = res_n + 2'd1;
      end

      // second word of an unknown escape
      if ((word_cnt == 2'd2) && !fin_w) begin
         if (words_w >= WORD_CAP) begin
            res[res_n[0]] = '{kind: KIND_WRONG, value: '0, words: words_w, last: 1'b0};
            fin_w = 1'b1;
         end else begin
            words_w = words_w + 7'd1;
            res[res_n[0]] = '{kind: KIND_WORD, value: wv1, words: words_w, last: 1'b0};
         end
         res_n = res_n + 2'd1;
      end

      // line end or error
      if (tail_req && !fin_w) begin
         res[res_n[0]] = '{kind: tail_kind, value: '0, words: words_w, last: 1'b0};
         fin_w = 1'b1;
         res_n = res_n + 2'd1;
      end

      // mark the final result of this transaction
      if (res_n == 2'd2) begin
         res[1].last = 1'b1;
      end else if (res_n == 2'd1) begin
         res[0].last = 1'b1;
      end

      words_in = words_w;
      fin_in   = fin_w;
   end

   // parser state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_PRE;
         neg_ff   <= 1'b0;
         mag_ff   <= '0;
         words_ff <= '0;
         fin_ff   <= 1'b0;
      end else if (req_take) begin
         phase_ff <= phase_in;
         neg_ff   <= neg_in;
         mag_ff   <= mag_in;
         words_ff <= words_in;
         fin_ff   <= fin_in;
      end
   end

   // queue pointers and fill count
   always_comb begin
      logic [2:0] pushed;
      pushed    = req_take ? {1'b0, res_n} : 3'd0;
      wr_ptr_in = wr_ptr_ff + pushed[1:0];
      rd_ptr_in = rd_ptr_ff + {1'b0, rsp_take};
      count_in  = count_ff + pushed - {2'b00, rsp_take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (req_take && (res_n != 2'd0)) begin
         queue_ff[wr_ptr_ff] <= res[0];
      end
      if (req_take && (res_n == 2'd2)) begin
         queue_ff[wr_ptr_ff + 2'd1] <= res[1];
      end
   end

   // need room for two results before taking a character
   assign req_stall = (count_ff > 3'(QUEUE_DEPTH - 2));

   // result channel
   assign rsp_valid      = (count_ff != 3'd0);
   assign rsp_kind       = queue_ff[rd_ptr_ff].kind;
   assign rsp_word_value = $signed(queue_ff[rd_ptr_ff].value);
   assign rsp_line_words = queue_ff[rd_ptr_ff].words;
   assign rsp_last       = queue_ff[rd_ptr_ff].last;

endmodule
